FILE: hdl/lrupr_pkg.sv
// shared constants for the lru page replacement unit
package lrupr_pkg;

  localparam int MAX_SLOTS_DEF = 8;
  localparam int PAGE_BITS_DEF = 16;

  localparam int CFG_W      = 4;
  localparam int SLOT_OUT_W = 3;
  localparam int COUNT_W    = 16;
  localparam int DATA_W     = 32;
  localparam int ADDR_W     = 3;

  localparam logic [CFG_W-1:0] SLOTS_RESET = 4'd8;

  // register word indexes
  localparam logic REG_SLOTS_IN_USE = 1'b0;

endpackage

FILE: hdl/lru_page_replacement_unit.sv
// lru page replacement unit: fully associative frame table with rank-based lru
//
// Takes one page reference per cycle (busy stays low). The reference is registered
// at the edge that samples start, compared against all active slots at once in the
// next cycle, and the result registered at the following edge. done is high for
// exactly one cycle, registered together with the result. The receiver cannot
// stall, so results must be taken as they appear. A hit makes its slot most
// recent; a miss fills the lowest empty active slot, else replaces the least
// recently used one. fault_count saturates and clears after a beat with last_ref
// set. slots_in_use (byte address 0) selects how many slots from slot 0 take
// part; 0 acts as 1, large values as MAX_SLOTS. Slot contents are undefined
// until first filled; no clearing pass is needed.
module lru_page_replacement_unit #(
  parameter int MAX_SLOTS = lrupr_pkg::MAX_SLOTS_DEF,
  parameter int PAGE_BITS = lrupr_pkg::PAGE_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  // reference channel
  input  logic                              start,
  output logic                              busy,
  input  logic [PAGE_BITS-1:0]              page,
  input  logic                              last_ref,
  // result channel
  output logic                              done,
  output logic                              fault,
  output logic [lrupr_pkg::SLOT_OUT_W-1:0]  slot,
  output logic [lrupr_pkg::COUNT_W-1:0]     fault_count,
  output logic                              run_end,
  // configuration
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [lrupr_pkg::ADDR_W-1:0]      paddr,
  input  logic [lrupr_pkg::DATA_W-1:0]      pwdata,
  output logic [lrupr_pkg::DATA_W-1:0]      prdata,
  output logic                              pready
);
  import lrupr_pkg::*;

  localparam int SLOT_W = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
  localparam int NACT_W = $clog2(MAX_SLOTS + 1) + 1;
  localparam logic [SLOT_W-1:0] RANK_MAX = SLOT_W'(MAX_SLOTS - 1);

  logic [CFG_W-1:0] slots_in_use;

  logic                 in_valid;
  logic [PAGE_BITS-1:0] in_page;
  logic                 in_last;

  logic [PAGE_BITS-1:0] slot_page [MAX_SLOTS];
  logic [MAX_SLOTS-1:0] slot_valid;
  logic [SLOT_W-1:0]    slot_rank [MAX_SLOTS];
  logic [COUNT_W-1:0]   faults_seen;

  logic [NACT_W-1:0]    n_act;
  logic [MAX_SLOTS-1:0] active;
  logic [MAX_SLOTS-1:0] match;
  logic [MAX_SLOTS-1:0] empty;
  logic                 hit;
  logic                 any_empty;
  logic [SLOT_W-1:0]    hit_idx;
  logic [SLOT_W-1:0]    empty_idx;
  logic [SLOT_W-1:0]    victim_idx;
  logic [SLOT_W-1:0]    best_rank;
  logic                 victim_found;
  logic [SLOT_W-1:0]    sel;
  logic                 age_all;
  logic [SLOT_W-1:0]    old_rank;
  logic [SLOT_W-1:0]    slot_rank_next [MAX_SLOTS];
  logic [COUNT_W-1:0]   count_next;
  logic                 cfg_write;

  assign busy   = 1'b0;
  assign pready = 1'b1;

  assign cfg_write = psel && penable && pwrite && pready;

  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_SLOTS_IN_USE) begin
      prdata = DATA_W'(slots_in_use);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slots_in_use <= SLOTS_RESET;
    end else if (cfg_write && paddr[2] == REG_SLOTS_IN_USE) begin
      slots_in_use <= pwdata[CFG_W-1:0];
    end
  end

  // clamp slot count
  always_comb begin
    if (slots_in_use == '0) begin
      n_act = NACT_W'(1);
    end else if (int'(slots_in_use) > MAX_SLOTS) begin
      n_act = NACT_W'(MAX_SLOTS);
    end else begin
      n_act = NACT_W'(slots_in_use);
    end
  end

  // parallel compare and lowest-index priority picks
  always_comb begin
    hit_idx   = '0;
    empty_idx = '0;
    for (int i = MAX_SLOTS - 1; i >= 0; i--) begin
      active[i] = (NACT_W'(i) < n_act);
      match[i]  = active[i] && slot_valid[i] && (slot_page[i] == in_page);
      empty[i]  = active[i] && !slot_valid[i];
      if (match[i]) begin
        hit_idx = SLOT_W'(i);
      end
      if (empty[i]) begin
        empty_idx = SLOT_W'(i);
      end
    end
    hit       = |match;
    any_empty = |empty;
  end

  // oldest active slot, ties to lowest index
  always_comb begin
    victim_idx   = '0;
    best_rank    = '0;
    victim_found = 1'b0;
    for (int i = 0; i < MAX_SLOTS; i++) begin
      if (active[i] && (!victim_found || slot_rank[i] > best_rank)) begin
        victim_found = 1'b1;
        best_rank    = slot_rank[i];
        victim_idx   = SLOT_W'(i);
      end
    end
  end

  always_comb begin
    if (hit) begin
      sel = hit_idx;
    end else if (any_empty) begin
      sel = empty_idx;
    end else begin
      sel = victim_idx;
    end
    // a fresh fill counts as older than everything
    age_all  = !hit && any_empty;
    old_rank = slot_rank[sel];
    for (int i = 0; i < MAX_SLOTS; i++) begin
      slot_rank_next[i] = slot_rank[i];
      if (SLOT_W'(i) == sel) begin
        slot_rank_next[i] = '0;
      end else if (active[i] && slot_valid[i] && (age_all || slot_rank[i] < old_rank)
                   && slot_rank[i] < RANK_MAX) begin
        slot_rank_next[i] = slot_rank[i] + 1'b1;
      end
    end
    count_next = faults_seen;
    if (!hit && faults_seen != '1) begin
      count_next = faults_seen + 1'b1;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      in_valid <= start && !busy;
    end
    if (start && !busy) begin
      in_page <= page;
      in_last <= last_ref;
    end
  end

  // frame table and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      done        <= 1'b0;
      slot_valid  <= '0;
      faults_seen <= '0;
      for (int i = 0; i < MAX_SLOTS; i++) begin
        slot_rank[i] <= '0;
      end
    end else begin
      done <= in_valid;
      if (in_valid) begin
        for (int i = 0; i < MAX_SLOTS; i++) begin
          slot_rank[i] <= slot_rank_next[i];
        end
        if (!hit) begin
          slot_valid[sel] <= 1'b1;
        end
        faults_seen <= in_last ? '0 : count_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid) begin
      if (!hit) begin
        slot_page[sel] <= in_page;
      end
      fault       <= !hit;
      slot        <= SLOT_OUT_W'(sel);
      fault_count <= count_next;
      run_end     <= in_last;
    end
  end

endmodule
